// ----- rtl/wls_pkg.sv -----
// Shared types, codes and constants of the WebSocket link supervisor.
package wls_pkg;

    localparam int unsigned MaxBackoffMs  = 60000;
    localparam int unsigned DefaultBaseMs = 1000;
    localparam int unsigned AttemptBits   = 8;
    localparam int unsigned CfgW          = 24;
    localparam int unsigned TimeW         = 32;
    localparam int unsigned DelayW        = $clog2(MaxBackoffMs + 1);

    typedef enum logic [1:0] {
        MODE_DISC       = 2'd0,
        MODE_CONNECTING = 2'd1,
        MODE_CONNECTED  = 2'd2,
        MODE_CLOSING    = 2'd3
    } mode_e_t;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_START  = 3'd1,
        ACT_CLOSE  = 3'd2,
        ACT_PING   = 3'd3,
        ACT_PONG   = 3'd4,
        ACT_OPEN   = 3'd5,
        ACT_MSG    = 3'd6,
        ACT_NCLOSE = 3'd7
    } act_e_t;

    typedef enum logic [3:0] {
        CMD_CONNECT    = 4'd0,
        CMD_DISCONNECT = 4'd1,
        CMD_SERVICE    = 4'd2,
        CMD_POLL       = 4'd3,
        CMD_TRANSPORT  = 4'd4,
        CMD_WS_OPEN    = 4'd5,
        CMD_MESSAGE    = 4'd6,
        CMD_CONTROL    = 4'd7,
        CMD_ERROR      = 4'd8,
        CMD_CLOSED     = 4'd9
    } cmd_e_t;

    typedef enum logic [1:0] {
        CFG_RECONNECT_BASE = 2'd0,
        CFG_PING_PERIOD    = 2'd1,
        CFG_STALE_LIMIT    = 2'd2
    } cfg_idx_e_t;

    localparam logic [3:0] OpcPing  = 4'd9;
    localparam logic [3:0] OpcClose = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BACKOFF,
        ST_APPLY,
        ST_OUT_FIRST,
        ST_OUT_SECOND
    } state_e_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic apply;
        logic sel_second;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic bo_done;
        logic two_results;
    } dp_stat_t;

endpackage

// ----- rtl/wls_ctrl.sv -----
// Sequencing state machine of the link supervisor: accept, backoff, apply, emit.
module wls_ctrl
    import wls_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output logic     m_tlast,
    output ctl_cmd_t cmd_o,
    input  dp_stat_t stat_i
);

    state_e_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        m_tlast    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd_o.load = 1'b1;
                    state_next = ST_BACKOFF;
                end
            end
            ST_BACKOFF: begin
                if (stat_i.bo_done) begin
                    state_next = ST_APPLY;
                end else begin
                    cmd_o.step = 1'b1;
                end
            end
            ST_APPLY: begin
                cmd_o.apply = 1'b1;
                state_next  = ST_OUT_FIRST;
            end
            ST_OUT_FIRST: begin
                m_tvalid = 1'b1;
                m_tlast  = !stat_i.two_results;
                if (m_tready) begin
                    state_next = stat_i.two_results ? ST_OUT_SECOND : ST_IDLE;
                end
            end
            ST_OUT_SECOND: begin
                m_tvalid         = 1'b1;
                m_tlast          = 1'b1;
                cmd_o.sel_second = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/wls_datapath.sv -----
// Link state, configuration registers, iterative backoff unit and result registers.
module wls_datapath
    import wls_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  ctl_cmd_t          cmd_i,
    output dp_stat_t          stat_o,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [CfgW-1:0]   cfg_data,
    input  logic [3:0]        command,
    input  logic [TimeW-1:0]  now_ms,
    input  logic              target_given,
    input  logic              link_ok,
    input  logic [3:0]        frame_opcode,
    output logic [2:0]        action,
    output logic [1:0]        link_state
);

    localparam logic [AttemptBits-1:0] AttemptMax = '1;
    localparam logic [DelayW-1:0]      CapD       = DelayW'(MaxBackoffMs);

    // Configuration
    logic [CfgW-1:0] base_reg, ping_reg, stale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= CfgW'(5000);
            ping_reg  <= CfgW'(15000);
            stale_reg <= CfgW'(30000);
        end else if (cfg_valid) begin
            unique case (cfg_idx_e_t'(cfg_index))
                CFG_RECONNECT_BASE: base_reg  <= cfg_data;
                CFG_PING_PERIOD:    ping_reg  <= cfg_data;
                CFG_STALE_LIMIT:    stale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Held item
    cmd_e_t           cmd_reg;
    logic [TimeW-1:0] now_reg;
    logic             tgt_reg, ok_reg;
    logic [3:0]       opc_reg;

    always_ff @(posedge aclk) begin
        if (cmd_i.load) begin
            cmd_reg <= cmd_e_t'(command);
            now_reg <= now_ms;
            tgt_reg <= target_given;
            ok_reg  <= link_ok;
            opc_reg <= frame_opcode;
        end
    end

    // Link state
    mode_e_t                mode_reg, mode_next;
    logic                   tgt_state_reg, tgt_state_next;
    logic [AttemptBits-1:0] att_reg, att_next;
    logic [TimeW-1:0]       last_att_reg, last_att_next;
    logic [TimeW-1:0]       last_ping_reg, last_ping_next;
    logic [TimeW-1:0]       last_rx_reg, last_rx_next;

    // Results
    act_e_t act0_reg, act0_next, act1_reg, act1_next;
    logic   two_reg, two_next;

    // Backoff unit: one doubling per cycle, clamped to the cap
    logic [CfgW-1:0]        base_eff;
    logic [DelayW-1:0]      bo_d_reg;
    logic [AttemptBits-1:0] bo_i_reg;
    logic [CfgW:0]          bo_sum;
    logic                   bo_over;
    logic [DelayW:0]        bo_dbl;

    assign base_eff = (base_reg == '0) ? CfgW'(DefaultBaseMs) : base_reg;
    assign bo_sum   = (CfgW + 1)'(bo_d_reg) + {1'b0, base_eff};
    assign bo_over  = bo_sum > (CfgW + 1)'(MaxBackoffMs);
    assign bo_dbl   = {bo_d_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (cmd_i.load) begin
            bo_d_reg <= (base_eff > CfgW'(MaxBackoffMs)) ? CapD : base_eff[DelayW-1:0];
            bo_i_reg <= '0;
        end else if (cmd_i.step) begin
            bo_d_reg <= (bo_dbl > (DelayW + 1)'(MaxBackoffMs)) ? CapD : bo_dbl[DelayW-1:0];
            bo_i_reg <= bo_i_reg + AttemptBits'(1);
        end
    end

    assign stat_o.bo_done     = (bo_i_reg == att_reg) || bo_over;
    assign stat_o.two_results = two_reg;

    // Step evaluation
    logic             live;
    logic [TimeW-1:0] since_att, since_ping, since_rx;
    logic             in_wait, may_attempt, ping_hit, stale_hit;

    always_comb begin
        live        = mode_reg != MODE_DISC;
        since_att   = now_reg - last_att_reg;
        since_ping  = now_reg - last_ping_reg;
        since_rx    = now_reg - last_rx_reg;
        in_wait     = (last_att_reg != '0) && (since_att < TimeW'(bo_d_reg));
        may_attempt = tgt_state_reg && !live && !in_wait && (base_reg != '0);
        ping_hit    = (mode_reg == MODE_CONNECTED) && (ping_reg != '0) &&
                      (since_ping >= TimeW'(ping_reg));
        stale_hit   = (mode_reg == MODE_CONNECTED) && (stale_reg != '0) &&
                      (since_rx > TimeW'(stale_reg));

        mode_next      = mode_reg;
        tgt_state_next = tgt_state_reg;
        att_next       = att_reg;
        last_att_next  = last_att_reg;
        last_ping_next = last_ping_reg;
        last_rx_next   = last_rx_reg;
        act0_next      = ACT_NONE;
        act1_next      = ACT_NONE;
        two_next       = 1'b0;

        unique case (cmd_reg)
            CMD_CONNECT: begin
                if (tgt_reg) begin
                    tgt_state_next = 1'b1;
                    att_next       = AttemptBits'(1);
                    last_att_next  = now_reg;
                    mode_next      = ok_reg ? MODE_CONNECTING : MODE_DISC;
                    act0_next      = ACT_START;
                end
            end
            CMD_DISCONNECT: begin
                if (live) begin
                    mode_next = MODE_CLOSING;
                    if (mode_reg == MODE_CONNECTED) begin
                        act0_next = ACT_CLOSE;
                    end
                end
            end
            CMD_SERVICE: begin
                if (may_attempt) begin
                    last_att_next = now_reg;
                    att_next      = (att_reg == AttemptMax) ? att_reg
                                                            : att_reg + AttemptBits'(1);
                    mode_next     = ok_reg ? MODE_CONNECTING : MODE_DISC;
                    act0_next     = ACT_START;
                end
            end
            CMD_POLL: begin
                if (ping_hit) begin
                    last_ping_next = now_reg;
                    act0_next      = ACT_PING;
                end
                if (stale_hit) begin
                    mode_next = MODE_CLOSING;
                    if (ping_hit) begin
                        act1_next = ACT_CLOSE;
                        two_next  = 1'b1;
                    end else begin
                        act0_next = ACT_CLOSE;
                    end
                end
            end
            CMD_TRANSPORT: begin
                if (live) begin
                    mode_next = MODE_CONNECTING;
                end
            end
            CMD_WS_OPEN: begin
                if (live) begin
                    mode_next      = MODE_CONNECTED;
                    last_rx_next   = now_reg;
                    last_ping_next = now_reg;
                    att_next       = '0;
                    act0_next      = ACT_OPEN;
                end
            end
            CMD_MESSAGE: begin
                if (live) begin
                    last_rx_next = now_reg;
                    act0_next    = ACT_MSG;
                end
            end
            CMD_CONTROL: begin
                if (live) begin
                    last_rx_next = now_reg;
                    if (opc_reg == OpcPing) begin
                        act0_next = ACT_PONG;
                    end else if (opc_reg == OpcClose) begin
                        mode_next = MODE_CLOSING;
                    end
                end
            end
            CMD_ERROR: begin
                if (live) begin
                    mode_next = MODE_DISC;
                end
            end
            CMD_CLOSED: begin
                if (live) begin
                    mode_next = MODE_DISC;
                    act0_next = ACT_NCLOSE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_DISC;
            tgt_state_reg <= 1'b0;
            att_reg       <= '0;
            last_att_reg  <= '0;
            last_ping_reg <= '0;
            last_rx_reg   <= '0;
            two_reg       <= 1'b0;
        end else if (cmd_i.apply) begin
            mode_reg      <= mode_next;
            tgt_state_reg <= tgt_state_next;
            att_reg       <= att_next;
            last_att_reg  <= last_att_next;
            last_ping_reg <= last_ping_next;
            last_rx_reg   <= last_rx_next;
            two_reg       <= two_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.apply) begin
            act0_reg <= act0_next;
            act1_reg <= act1_next;
        end
    end

    assign action     = cmd_i.sel_second ? act1_reg : act0_reg;
    assign link_state = mode_reg;

endmodule

// ----- rtl/websocket_link_supervisor.sv -----
// Top level of the WebSocket link supervisor: controller, datapath and checks.
//
//  channel  | direction | beat moves                        | done when
//  ---------+-----------+-----------------------------------+-----------------------
//  s_       | in        | one timestamped link event        | s_tvalid & s_tready
//  m_       | out       | one action with the link state    | m_tvalid & m_tready
//  cfg_     | in        | one register write (index, data)  | cfg_valid & cfg_ready
//
// One event at a time: accept, then the backoff unit (one doubling per cycle until the attempt
// count is reached or the delay plus the base exceeds the cap, then it is seen done), then
// apply, then one or two result beats, each of which may wait on m_tready.
// Reset is synchronous on aresetn low; no clearing pass is needed.
// A stalled result beat holds m_tdata and m_tlast; s_tready stays low until
// the last beat of the event has gone.
module websocket_link_supervisor
    import wls_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] now_ms, [32] target_given, [33] link_ok, [37:34] frame_opcode, [39:38] zero
    input  logic [39:0] s_tdata,
    // [3:0] command
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] action, [4:3] link_state, [7:5] zero
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    ctl_cmd_t   ctl_cmd;
    dp_stat_t   dp_stat;
    logic [2:0] action;
    logic [1:0] link_state;

    // Registers take a write in any cycle; the user must write only while idle, the block does not enforce it.
    assign cfg_ready = 1'b1;

    wls_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .cmd_o    (ctl_cmd),
        .stat_i   (dp_stat)
    );

    wls_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_i        (ctl_cmd),
        .stat_o       (dp_stat),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .command      (s_tuser),
        .now_ms       (s_tdata[31:0]),
        .target_given (s_tdata[32]),
        .link_ok      (s_tdata[33]),
        .frame_opcode (s_tdata[37:34]),
        .action       (action),
        .link_state   (link_state)
    );

    // Pack the result beat: action lowest, then the link state.
    assign m_tdata = {3'b000, link_state, action};

    // Never take an event while a result is on offer.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // An accepted event is not answered in the very next cycle.
    a_accept_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result offered straight after accept");

    // The final beat of an event returns the block to idle.
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("block not idle after the last result beat");

endmodule
